/* hw/rtl/rtcm_fr_pkg.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// RTCM3 framer package
// Shared types and constants for the RTCM3 frame extractor.
// -----------------------------------------------------------------------------
package rtcm_fr_pkg;

  localparam logic [7:0]  Preamble  = 8'hD3;
  localparam logic [23:0] CrcPoly   = 24'h864CFB;
  localparam logic [7:0]  RsvdMask  = 8'hFC;
  localparam int unsigned FrameOvh  = 6;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_HDR1,
    ST_HDR2,
    ST_CRC_RD,
    ST_CRC_BYTE,
    ST_EXP,
    ST_CMP,
    ST_COPY,
    ST_DONE_FAIL,
    ST_FRAME_RD,
    ST_OUT
  } st_e;

  // Advance the CRC-24Q register by one byte, bitwise.
  function automatic logic [23:0] crc24q_byte(logic [23:0] crc, logic [7:0] b);
    logic [23:0] c;
    c = crc ^ {b, 16'h0};
    for (int k = 0; k < 8; k++) begin
      if (c[23]) c = {c[22:0], 1'b0} ^ CrcPoly;
      else       c = {c[22:0], 1'b0};
    end
    return c;
  endfunction

endpackage

/* hw/rtl/rtcm3_frame_resync_extractor_core.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// RTCM3 frame resync extractor
// Buffers received bytes, finds CRC-24Q checked RTCM3 frames, hands them out
// one byte per pull transfer.
// -----------------------------------------------------------------------------
//  channel | signals                             | direction
//  in      | in_valid_i in_stall_o kind_i in_byte_i | into block
//  out     | out_valid_o out_stall_i out_ok_o out_byte_o out_last_o | from block
//
//  Byte transfer: written to the receive RAM.
//  Pull with a pending frame: frame RAM read, then output register.
//  Pull that searches: at most one RAM read per cycle; a skip reads and then
//  checks each byte, the CRC check reads and then folds each frame byte, the copy
//  writes each byte as the next is read. The single read port of the receive RAM sets this pace.
//  Reset clears state, pointers, counts and output valid; RAM contents stay undefined.
//  in_stall_o is high while an item is in work or a result waits on out.
// -----------------------------------------------------------------------------
module rtcm3_frame_resync_extractor_core
  import rtcm_fr_pkg::*;
#(
  parameter int unsigned BUFFER_BYTES    = 1030,
  parameter int unsigned MAX_FRAME_BYTES = 1029
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       kind_i,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       out_ok_o,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);

  localparam int unsigned AW = $clog2(BUFFER_BYTES);
  localparam int unsigned CW = $clog2(BUFFER_BYTES + 1);
  localparam int unsigned FAW = $clog2(MAX_FRAME_BYTES);
  localparam int unsigned FCW = $clog2(MAX_FRAME_BYTES + 1);
  localparam int unsigned LW = (CW > 11) ? CW : 11;  // frame length width
  localparam logic [AW-1:0] LastPos = AW'(BUFFER_BYTES - 1);

  // memories
  logic [7:0] rx_mem [BUFFER_BYTES];
  logic [7:0] fr_mem [MAX_FRAME_BYTES];
  logic [7:0] rx_rd_q, fr_rd_q;

  st_e st_q, st_d;
  logic [AW-1:0]  start_q, start_d;
  logic [CW-1:0]  count_q, count_d;
  logic [FCW-1:0] flen_q, flen_d;     // pending frame length
  logic [FCW-1:0] fidx_q, fidx_d;
  logic [LW-1:0]  clen_q, clen_d;     // candidate length
  logic [LW-1:0]  i_q, i_d;           // walk index
  logic [23:0]    crc_q, crc_d, exp_d, exp_q;
  logic [7:0]     h1_q, h1_d;
  logic           ov_q, ov_d, ook_q, ook_d, olast_q, olast_d;
  logic [7:0]     obyte_q, obyte_d;

  // receive and frame RAM ports
  logic          rx_we, rx_re, fr_we, fr_re;
  logic [AW-1:0] rx_wa, rx_ra;
  logic [FAW-1:0] fr_wa, fr_ra;
  logic [7:0]    fr_wd;

  // position of logical index within circular buffer
  function automatic logic [AW-1:0] pos(logic [AW-1:0] s, logic [LW-1:0] i);
    logic [AW+LW:0] t;
    t = (AW+LW+1)'(s) + (AW+LW+1)'(i);
    if (t >= (AW+LW+1)'(BUFFER_BYTES)) t = t - (AW+LW+1)'(BUFFER_BYTES);
    return t[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] inc(logic [AW-1:0] s);
    return (s == LastPos) ? '0 : s + 1'b1;
  endfunction

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;
  assign in_stall_o = (st_q != ST_IDLE) || ov_q;

  always_ff @(posedge clk_i) begin
    if (rx_we) rx_mem[rx_wa] <= in_byte_i;
    if (rx_re) rx_rd_q <= rx_mem[rx_ra];
    if (fr_we) fr_mem[fr_wa] <= fr_wd;
    if (fr_re) fr_rd_q <= fr_mem[fr_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; start_q <= '0; count_q <= '0; flen_q <= '0; fidx_q <= '0;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d; start_q <= start_d; count_q <= count_d; flen_q <= flen_d;
      fidx_q <= fidx_d; ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    clen_q <= clen_d; i_q <= i_d; crc_q <= crc_d; exp_q <= exp_d; h1_q <= h1_d;
    ook_q <= ook_d; olast_q <= olast_d; obyte_q <= obyte_d;
  end

  logic [LW-1:0] cnt_l;
  assign cnt_l = LW'(count_q);

  always_comb begin
    st_d = st_q; start_d = start_q; count_d = count_q; flen_d = flen_q;
    fidx_d = fidx_q; clen_d = clen_q; i_d = i_q; crc_d = crc_q; exp_d = exp_q;
    h1_d = h1_q; ov_d = ov_q; ook_d = ook_q; olast_d = olast_q; obyte_d = obyte_q;
    rx_we = 1'b0; rx_re = 1'b0; fr_we = 1'b0; fr_re = 1'b0;
    rx_wa = pos(start_q, cnt_l); rx_ra = start_q;
    fr_wa = FAW'(i_q); fr_ra = FAW'(fidx_q); fr_wd = rx_rd_q;

    if (ov_q && !out_stall_i) ov_d = 1'b0;

    unique case (st_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (!kind_i) begin
            rx_we = 1'b1;
            if (count_q == CW'(BUFFER_BYTES)) begin
              // full: overwrite oldest
              rx_wa = start_q;
              start_d = inc(start_q);
            end else begin
              count_d = count_q + 1'b1;
            end
          end else if (flen_q != '0) begin
            st_d = ST_FRAME_RD;
          end else begin
            st_d = ST_SCAN_RD;
          end
        end
      end
      ST_SCAN_RD: begin
        if (count_q == '0) begin
          start_d = '0;
          st_d = ST_DONE_FAIL;
        end else begin
          rx_re = 1'b1; rx_ra = start_q;
          st_d = ST_SCAN_CHK;
        end
      end
      ST_SCAN_CHK: begin
        if (rx_rd_q != Preamble) begin
          start_d = inc(start_q); count_d = count_q - 1'b1;
          st_d = ST_SCAN_RD;
        end else if (cnt_l < LW'(3)) begin
          st_d = ST_DONE_FAIL;
        end else begin
          rx_re = 1'b1; rx_ra = pos(start_q, LW'(1));
          st_d = ST_HDR1;
        end
      end
      ST_HDR1: begin
        h1_d = rx_rd_q;
        if ((rx_rd_q & RsvdMask) != 8'h0) begin
          start_d = inc(start_q); count_d = count_q - 1'b1;
          st_d = ST_SCAN_RD;
        end else begin
          rx_re = 1'b1; rx_ra = pos(start_q, LW'(2));
          st_d = ST_HDR2;
        end
      end
      ST_HDR2: begin
        clen_d = LW'({h1_q[1:0], rx_rd_q}) + LW'(FrameOvh);
        if (clen_d > LW'(MAX_FRAME_BYTES)) begin
          start_d = inc(start_q); count_d = count_q - 1'b1;
          st_d = ST_SCAN_RD;
        end else if (cnt_l < clen_d) begin
          st_d = ST_DONE_FAIL;
        end else begin
          i_d = '0; crc_d = '0;
          st_d = ST_CRC_RD;
        end
      end
      ST_CRC_RD: begin
        rx_re = 1'b1; rx_ra = pos(start_q, i_q);
        st_d = ST_CRC_BYTE;
      end
      ST_CRC_BYTE: begin
        if (i_q < clen_q - LW'(3)) crc_d = crc24q_byte(crc_q, rx_rd_q);
        else exp_d = {exp_q[15:0], rx_rd_q};
        i_d = i_q + 1'b1;
        st_d = (i_d == clen_q) ? ST_CMP : ST_CRC_RD;
      end
      ST_CMP: begin
        if (crc_q != exp_q) begin
          start_d = inc(start_q); count_d = count_q - 1'b1;
          st_d = ST_SCAN_RD;
        end else begin
          i_d = '0;
          rx_re = 1'b1; rx_ra = start_q;
          st_d = ST_COPY;
        end
      end
      ST_EXP: st_d = ST_CMP;
      ST_COPY: begin
        fr_we = 1'b1; fr_wa = FAW'(i_q); fr_wd = rx_rd_q;
        i_d = i_q + 1'b1;
        if (i_d == clen_q) begin
          flen_d = FCW'(clen_q); fidx_d = '0;
          start_d = pos(start_q, clen_q);
          count_d = count_q - CW'(clen_q);
          st_d = ST_FRAME_RD;
        end else begin
          rx_re = 1'b1; rx_ra = pos(start_q, i_d);
        end
      end
      ST_DONE_FAIL: begin
        ov_d = 1'b1; ook_d = 1'b0; obyte_d = '0; olast_d = 1'b0;
        st_d = ST_IDLE;
      end
      ST_FRAME_RD: begin
        fr_re = 1'b1; fr_ra = FAW'(fidx_q);
        st_d = ST_OUT;
      end
      ST_OUT: begin
        ov_d = 1'b1; ook_d = 1'b1; obyte_d = fr_rd_q;
        olast_d = (fidx_q + 1'b1 >= flen_q);
        if (olast_d) begin
          flen_d = '0; fidx_d = '0;
        end else begin
          fidx_d = fidx_q + 1'b1;
        end
        st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = ov_q;
  assign out_ok_o    = ook_q;
  assign out_byte_o  = obyte_q;
  assign out_last_o  = olast_q;

  // assertions
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(BUFFER_BYTES)) else $error("rx count overflow");
  a_flen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flen_q <= FCW'(MAX_FRAME_BYTES)) else $error("frame length too big");
  a_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (flen_q != '0) |-> (fidx_q < flen_q)) else $error("frame index past end");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != ST_IDLE) |-> in_stall_o) else $error("input open while busy");
  a_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !ook_q) |-> !out_last_o) else $error("last on empty result");

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// RTCM3 frame resync extractor testbench
// Feeds byte and pull transfers into the core and predicts every pull result
// with a local model of the receive store, the frame search and the CRC-24Q
// check. Covers empty pulls, broken headers, bad CRCs, store overflow, a
// maximum length frame, random traffic and long output back-pressure.
// -----------------------------------------------------------------------------
module tb
  import rtcm_fr_pkg::*;
();

  localparam int unsigned RxDepth  = 1030;
  localparam int unsigned MaxFrame = 1029;
  localparam int unsigned HoldLen  = 400;
  localparam logic        KindByte = 1'b0;
  localparam logic        KindPull = 1'b1;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic       kind_i = 1'b0;
  logic [7:0] in_byte_i = 8'h00;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic       out_ok_o;
  logic [7:0] out_byte_o;
  logic       out_last_o;

  typedef struct packed {
    logic       ok;
    logic [7:0] data;
    logic       last;
  } pull_res_t;

  // receive store / frame store mirror
  logic [7:0] rx_mem [RxDepth];
  int unsigned rx_head, rx_fill;
  logic [7:0] frm_mem [MaxFrame];
  int unsigned frm_len, frm_idx;

  pull_res_t pull_q [$];
  int errors = 0;
  int n_items = 0, n_pulls = 0, n_frames_out = 0;
  bit quiet = 1'b0;
  int hold_seq = 0, hold_seen = 0, hold_left = 0;

  rtcm3_frame_resync_extractor_core dut (.*);

  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] rx_peek(int unsigned i);
    return rx_mem[(rx_head + i) % RxDepth];
  endfunction

  function automatic void rx_discard(int unsigned n);
    if (n > rx_fill) n = rx_fill;
    rx_head = (rx_head + n) % RxDepth;
    rx_fill -= n;
  endfunction

  function automatic logic [23:0] rx_crc(int unsigned len);
    logic [24:0] c;
    c = '0;
    for (int unsigned i = 0; i < len; i++) begin
      c[23:16] ^= rx_peek(i);
      for (int b = 0; b < 8; b++) begin
        c = {c[23:0], 1'b0};
        if (c[24]) c ^= 25'h1864CFB;
      end
    end
    return c[23:0];
  endfunction

  // Scan for a good frame; moves it to the frame store on success.
  function automatic bit find_frame();
    int unsigned flen;
    logic [7:0] hdr1;
    forever begin
      while (rx_fill > 0 && rx_peek(0) != Preamble) rx_discard(1);
      if (rx_fill == 0) begin
        rx_head = 0;
        return 1'b0;
      end
      if (rx_fill < 3) return 1'b0;
      hdr1 = rx_peek(1);
      if ((hdr1 & RsvdMask) != 0) begin
        rx_discard(1);
        continue;
      end
      flen = {hdr1[1:0], rx_peek(2)} + FrameOvh;
      if (flen > MaxFrame) begin
        rx_discard(1);
        continue;
      end
      if (rx_fill < flen) return 1'b0;
      if (rx_crc(flen - 3) != {rx_peek(flen - 3), rx_peek(flen - 2), rx_peek(flen - 1)}) begin
        rx_discard(1);
        continue;
      end
      for (int unsigned i = 0; i < flen; i++) frm_mem[i] = rx_peek(i);
      frm_len = flen;
      frm_idx = 0;
      rx_discard(flen);
      return 1'b1;
    end
  endfunction

  function automatic void predict(logic kind, logic [7:0] data);
    pull_res_t r;
    int unsigned idx;
    if (kind == KindByte) begin
      if (rx_fill >= RxDepth) rx_discard(1);
      rx_mem[(rx_head + rx_fill) % RxDepth] = data;
      rx_fill++;
      return;
    end
    n_pulls++;
    if (frm_len == 0 && !find_frame()) begin
      r = '0;
    end else begin
      idx = frm_idx;
      if (idx >= frm_len) idx = 0;
      r.ok   = 1'b1;
      r.data = frm_mem[idx];
      r.last = (idx + 1 >= frm_len);
      if (r.last) begin
        frm_len = 0;
        frm_idx = 0;
        n_frames_out++;
      end else begin
        frm_idx = idx + 1;
      end
    end
    pull_q.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // sender: one transfer, random gap before it
  // ---------------------------------------------------------------------------
  task automatic send_item(logic kind, logic [7:0] data);
    if (!quiet && $urandom_range(99) < 17) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    in_byte_i  <= data;
    forever begin
      @(negedge clk_i);
      if (!in_stall_o) break;
    end
    @(posedge clk_i);
    predict(kind, data);
    n_items++;
  endtask

  task automatic send_pulls(int n);
    repeat (n) send_item(KindPull, 8'($urandom_range(255)));
  endtask

  // Whole frame with correct or corrupted CRC.
  task automatic send_frame(int unsigned plen, bit bad_crc);
    logic [7:0] f [$];
    logic [24:0] c;
    f.push_back(Preamble);
    f.push_back({6'b0, plen[9:8]});
    f.push_back(plen[7:0]);
    repeat (plen) f.push_back(8'($urandom_range(255)));
    c = '0;
    foreach (f[i]) begin
      c[23:16] ^= f[i];
      for (int b = 0; b < 8; b++) begin
        c = {c[23:0], 1'b0};
        if (c[24]) c ^= 25'h1864CFB;
      end
    end
    if (bad_crc) c[$urandom_range(23)] ^= 1'b1;
    f.push_back(c[23:16]);
    f.push_back(c[15:8]);
    f.push_back(c[7:0]);
    foreach (f[i]) send_item(KindByte, f[i]);
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random stall, plus long hold-off on request
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= HoldLen;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
    out_stall_i <= (hold_left > 1) || (!quiet && $urandom_range(99) < 17);
  end

  // Outputs are stable around negedge; a transfer seen here completes at the
  // next rising edge.
  always @(negedge clk_i) begin
    pull_res_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pull_q.size() == 0) begin
        $error("result with no pull outstanding");
        errors++;
      end else begin
        e = pull_q.pop_front();
        if (out_ok_o !== e.ok) begin
          $error("out_ok: expected %0d got %0d", e.ok, out_ok_o);
          errors++;
        end
        if (out_byte_o !== e.data) begin
          $error("out_byte: expected %02h got %02h", e.data, out_byte_o);
          errors++;
        end
        if (out_last_o !== e.last) begin
          $error("out_last: expected %0d got %0d", e.last, out_last_o);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    send_pulls(1);                          // empty store
    send_item(KindByte, 8'h00);
    send_item(KindByte, 8'hFF);
    send_pulls(1);                          // no preamble: store emptied
    send_item(KindByte, Preamble);
    send_pulls(1);                          // incomplete header
    send_item(KindByte, 8'hFC);             // reserved bits set
    send_item(KindByte, 8'h00);
    send_frame(0, 1'b0);
    send_pulls(7);                          // resync, six bytes, then none
    send_frame(2, 1'b1);                    // CRC failure
    send_frame(1, 1'b0);
    send_pulls(8);
  endtask

  task automatic test_overflow();
    repeat (RxDepth + 12) send_item(KindByte, 8'($urandom_range(255)));
    send_frame(4, 1'b0);
    send_pulls(12);
  endtask

  task automatic test_max_frame();
    quiet = 1'b1;
    send_frame(MaxFrame - FrameOvh, 1'b0);
    send_pulls(MaxFrame + 2);
    quiet = 1'b0;
  endtask

  task automatic test_random(int target);
    int stop_at;
    int sel;
    stop_at = n_items + target;
    while (n_items < stop_at) begin
      quiet = ($urandom_range(99) < 10);
      sel = $urandom_range(99);
      if (sel < 65) begin
        send_frame($urandom_range(99) < 90 ? $urandom_range(20) : $urandom_range(120),
                   $urandom_range(99) < 15);
        send_pulls($urandom_range(30));
      end else if (sel < 80) begin
        repeat ($urandom_range(6, 1)) send_item(KindByte, 8'($urandom_range(255)));
      end else if (sel < 88) begin
        send_item(KindByte, Preamble);      // broken header
        send_item(KindByte, 8'($urandom_range(255)));
      end else begin
        send_pulls($urandom_range(8, 1));
      end
    end
    quiet = 1'b0;
  endtask

  task automatic test_backpressure();
    hold_seq++;
    repeat (3) begin
      send_frame($urandom_range(10), 1'b0);
      send_pulls(8);
    end
  endtask

  initial begin
    rx_head = 0;
    rx_fill = 0;
    frm_len = 0;
    frm_idx = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_overflow();
    test_max_frame();
    test_backpressure();
    test_random(800);
    in_valid_i <= 1'b0;
    while (pull_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("Sent %0d transfers, %0d pulls, %0d frames delivered.",
             n_items, n_pulls, n_frames_out);
    if (errors == 0) $display("** rtcm3_frame_resync_extractor_core: PASSED **");
    else $display("** rtcm3_frame_resync_extractor_core: FAILED **");
    $finish;
  end

  initial begin
    #40ms;
    $display("timeout, %0d results outstanding", pull_q.size());
    $display("** rtcm3_frame_resync_extractor_core: FAILED **");
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/rtcm_fr_pkg.sv
hw/rtl/rtcm3_frame_resync_extractor_core.sv
dv/tb.sv
